// ===== src/short_circuit_breaker_fsm_assert.svh =====
// Assertion macros for the short-circuit breaker checks
`ifndef SHORT_CIRCUIT_BREAKER_FSM_ASSERT_SVH
`define SHORT_CIRCUIT_BREAKER_FSM_ASSERT_SVH

// same-cycle implication under active-low reset
`define SCB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("short circuit breaker check failed");

// next-cycle implication under active-low reset
`define SCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("short circuit breaker check failed");

`endif

// ===== src/scb_pkg.sv =====
// Types and constants shared by the short-circuit breaker modules
package scb_pkg;

    localparam int TRIP_LEVEL_BITS = 10;
    localparam int BACKOFF_BITS    = 14;

    localparam logic [BACKOFF_BITS-1:0] BACKOFF_STEP = 14'd500;
    localparam logic [BACKOFF_BITS-1:0] BACKOFF_CAP  = 14'd16383;
    localparam logic [7:0]              SHORT_CNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_REV   = 3'd1,
        ST_SCOFF = 3'd2,
        ST_COOL  = 3'd3,
        ST_AWAIT = 3'd4
    } prot_state_t;

    localparam logic [1:0] MODE_MANUAL      = 2'd0;
    localparam logic [1:0] MODE_LIMITED     = 2'd1;
    localparam logic [1:0] MODE_PROGRESSIVE = 2'd2;

    localparam logic [2:0] CFG_TRIP_LEVEL      = 3'd0;
    localparam logic [2:0] CFG_SHORT_LIMIT     = 3'd1;
    localparam logic [2:0] CFG_AUTO_REVERSE    = 3'd2;
    localparam logic [2:0] CFG_RESET_MODE      = 3'd3;
    localparam logic [2:0] CFG_RETRY_WAIT      = 3'd4;
    localparam logic [2:0] CFG_RETRY_LIMIT     = 3'd5;
    localparam logic [2:0] CFG_OVL_TRIP        = 3'd6;
    localparam logic [2:0] CFG_OVL_RESTORE     = 3'd7;

    typedef struct packed {
        logic [TRIP_LEVEL_BITS-1:0] trip_level;
        logic [4:0]                 short_count_limit;
        logic                       auto_reverse;
        logic [1:0]                 reset_mode;
        logic [15:0]                retry_wait_ms;
        logic [4:0]                 retry_limit;
        logic [15:0]                overload_trip_pct;
        logic [15:0]                overload_restore_pct;
    } scb_cfg_t;

    typedef struct packed {
        prot_state_t             state;
        logic                    ext_run;
        logic                    line_on;
        logic                    polarity;
        logic [7:0]              short_count;
        logic [31:0]             trip_time;
        logic [BACKOFF_BITS-1:0] backoff_ms;
    } prot_ctx_t;

endpackage

// ===== src/scb_step.sv =====
// Next-state logic of the protection controller for one transaction
module scb_step
    import scb_pkg::*;
#(
    parameter int SAMPLE_BITS    = 10,
    parameter int MAX_BACKOFF_MS = 10000
)
(
    input  prot_ctx_t              ctx,
    input  scb_cfg_t               cfg,
    input  cmd_t                   cmd,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [31:0]            now_ms,
    input  logic [15:0]            overload_pct,
    output prot_ctx_t              ctx_next
);

    localparam int CMP_BITS = (SAMPLE_BITS > TRIP_LEVEL_BITS) ? SAMPLE_BITS : TRIP_LEVEL_BITS;

    function automatic logic [BACKOFF_BITS-1:0] grow(input logic [BACKOFF_BITS-1:0] b);
        logic [BACKOFF_BITS:0] v;
        v = {1'b0, b} + {1'b0, BACKOFF_STEP};
        grow = (v > {1'b0, BACKOFF_CAP}) ? BACKOFF_CAP : v[BACKOFF_BITS-1:0];
    endfunction

    logic                    is_short;
    logic [31:0]             elapsed;
    logic [7:0]              cnt_inc;
    logic [BACKOFF_BITS-1:0] grown;
    logic [BACKOFF_BITS:0]   retry_span;

    assign is_short   = CMP_BITS'(sample) > CMP_BITS'(cfg.trip_level);
    assign elapsed    = now_ms - ctx.trip_time;
    assign cnt_inc    = (ctx.short_count < SHORT_CNT_MAX) ? ctx.short_count + 8'd1
                                                          : ctx.short_count;
    assign grown      = grow(ctx.backoff_ms);
    assign retry_span = (BACKOFF_BITS+1)'(cfg.retry_limit) * (BACKOFF_BITS+1)'(BACKOFF_STEP);

    always_comb
    begin
        ctx_next = ctx;
        case (cmd)
            CMD_TICK:
            begin
                case (ctx.state)
                    ST_OK, ST_REV:
                    begin
                        if (is_short && ctx.state == ST_OK && cfg.auto_reverse)
                        begin
                            ctx_next.polarity = ~ctx.polarity;
                            ctx_next.state    = ST_REV;
                        end
                        else if (is_short)
                        begin
                            ctx_next.short_count = cnt_inc;
                            if (cnt_inc > {3'b000, cfg.short_count_limit})
                            begin
                                ctx_next.line_on     = 1'b0;
                                ctx_next.trip_time   = now_ms;
                                ctx_next.short_count = 8'd0;
                                ctx_next.state       = ST_SCOFF;
                            end
                        end
                        else if (ctx.state == ST_OK)
                        begin
                            ctx_next.backoff_ms = BACKOFF_STEP;
                        end
                        else
                        begin
                            ctx_next.state = ST_OK;
                        end
                    end
                    ST_SCOFF:
                    begin
                        case (cfg.reset_mode)
                            MODE_MANUAL:
                            begin
                                ctx_next.state = ST_AWAIT;
                            end
                            MODE_LIMITED:
                            begin
                                if (elapsed > {16'd0, cfg.retry_wait_ms})
                                begin
                                    ctx_next.backoff_ms = grown;
                                    if ({1'b0, grown} < retry_span)
                                    begin
                                        ctx_next.state   = ST_OK;
                                        ctx_next.line_on = 1'b1;
                                    end
                                    else
                                    begin
                                        ctx_next.state = ST_AWAIT;
                                    end
                                end
                            end
                            MODE_PROGRESSIVE:
                            begin
                                if (elapsed > 32'(ctx.backoff_ms))
                                begin
                                    if (ctx.backoff_ms < BACKOFF_BITS'(MAX_BACKOFF_MS))
                                    begin
                                        ctx_next.backoff_ms = grown;
                                    end
                                    ctx_next.state   = ST_OK;
                                    ctx_next.line_on = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    ST_COOL:
                    begin
                        if (overload_pct < cfg.overload_restore_pct)
                        begin
                            if (cfg.reset_mode != MODE_MANUAL)
                            begin
                                ctx_next.state   = ST_OK;
                                ctx_next.line_on = 1'b1;
                            end
                            else
                            begin
                                ctx_next.state = ST_AWAIT;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (overload_pct > cfg.overload_trip_pct)
                begin
                    ctx_next.line_on     = 1'b0;
                    ctx_next.trip_time   = now_ms;
                    ctx_next.short_count = 8'd0;
                    ctx_next.state       = ST_COOL;
                end
            end
            CMD_RESET:
            begin
                if (ctx.state == ST_AWAIT)
                begin
                    ctx_next.state   = ST_OK;
                    ctx_next.ext_run = 1'b1;
                    ctx_next.line_on = 1'b1;
                end
            end
            CMD_RUN:
            begin
                ctx_next.state   = ST_OK;
                ctx_next.ext_run = 1'b1;
                ctx_next.line_on = 1'b1;
            end
            default:
            begin
                ctx_next.state       = ST_OK;
                ctx_next.ext_run     = 1'b0;
                ctx_next.line_on     = 1'b0;
                ctx_next.trip_time   = now_ms;
                ctx_next.short_count = 8'd0;
            end
        endcase
    end

endmodule

// ===== src/short_circuit_breaker_fsm.sv =====
// The input register refills as the result moves on, and holds while the output stalls.
// Throughput: one transaction per cycle unless the output stalls.
// The result fields are the protection state register itself, updated when a transaction
// leaves the input register. Reset clears state to ok, line off, forward, stopped,
// backoff 500 ms, and loads the register defaults; both valid flags drop.
module short_circuit_breaker_fsm
    import scb_pkg::*;
#(
    parameter int SAMPLE_BITS    = 10,
    parameter int MAX_BACKOFF_MS = 10000
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [31:0]            now_ms,
    input  logic [15:0]            overload_pct,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   line_on,
    output logic                   polarity,
    output logic [2:0]             prot_state,
    output logic                   ext_run,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    scb_cfg_t               cfg_reg;
    prot_ctx_t              ctx_reg;
    prot_ctx_t              ctx_next;
    logic                   in_valid_reg;
    cmd_t                   cmd_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [31:0]            now_reg;
    logic [15:0]            olf_reg;
    logic                   out_valid_reg;
    logic                   fire;

    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trip_level           <= 10'd1023;
            cfg_reg.short_count_limit    <= 5'd3;
            cfg_reg.auto_reverse         <= 1'b0;
            cfg_reg.reset_mode           <= MODE_PROGRESSIVE;
            cfg_reg.retry_wait_ms        <= 16'd500;
            cfg_reg.retry_limit          <= 5'd3;
            cfg_reg.overload_trip_pct    <= 16'd100;
            cfg_reg.overload_restore_pct <= 16'd80;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TRIP_LEVEL:   cfg_reg.trip_level           <= cfg_data[TRIP_LEVEL_BITS-1:0];
                CFG_SHORT_LIMIT:  cfg_reg.short_count_limit    <= cfg_data[4:0];
                CFG_AUTO_REVERSE: cfg_reg.auto_reverse         <= cfg_data[0];
                CFG_RESET_MODE:   cfg_reg.reset_mode           <= cfg_data[1:0];
                CFG_RETRY_WAIT:   cfg_reg.retry_wait_ms        <= cfg_data;
                CFG_RETRY_LIMIT:  cfg_reg.retry_limit          <= cfg_data[4:0];
                CFG_OVL_TRIP:     cfg_reg.overload_trip_pct    <= cfg_data;
                CFG_OVL_RESTORE:  cfg_reg.overload_restore_pct <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // hold the payload while the stage waits
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg    <= cmd_t'(cmd);
            sample_reg <= sample;
            now_reg    <= now_ms;
            olf_reg    <= overload_pct;
        end
    end

    scb_step #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_BACKOFF_MS (MAX_BACKOFF_MS)
    ) u_step (
        .ctx          (ctx_reg),
        .cfg          (cfg_reg),
        .cmd          (cmd_reg),
        .sample       (sample_reg),
        .now_ms       (now_reg),
        .overload_pct (olf_reg),
        .ctx_next     (ctx_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.state       <= ST_OK;
            ctx_reg.ext_run     <= 1'b0;
            ctx_reg.line_on     <= 1'b0;
            ctx_reg.polarity    <= 1'b0;
            ctx_reg.short_count <= 8'd0;
            ctx_reg.trip_time   <= 32'd0;
            ctx_reg.backoff_ms  <= BACKOFF_STEP;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                ctx_reg <= ctx_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_on    = ctx_reg.line_on;
    assign polarity   = ctx_reg.polarity;
    assign prot_state = ctx_reg.state;
    assign ext_run    = ctx_reg.ext_run;

endmodule

// ===== src/scb_checker.sv =====
// Port-level checks for the short-circuit breaker and their binding
`include "short_circuit_breaker_fsm_assert.svh"

module scb_checker
    import scb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       line_on,
    input logic [2:0] prot_state
);

    `SCB_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid)
    `SCB_ASSERT_IMPLY(a_in_stall_cause, clk, rst_n, in_valid && !in_ready,
                      out_valid && !out_ready)
    `SCB_ASSERT_IMPLY(a_line_off_when_tripped, clk, rst_n,
                      prot_state == ST_SCOFF || prot_state == ST_COOL || prot_state == ST_AWAIT,
                      !line_on)

endmodule

bind short_circuit_breaker_fsm scb_checker u_scb_checker (.*);
